// ----- rtl/dpds_pkg.sv -----
// Package for the density peak delta search block.
// Holds the sizing constants and the sequencer types used by the top level.
// Depends on nothing.
package dpds_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;

	localparam int COORD_IN_W = 16;
	localparam int CUT_W      = 33;
	localparam int OUT_IDX_W  = 6;
	localparam int OUT_DENS_MAX = 63;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DENS_W = IDX_W;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int CMP_W  = (DIST_W > CUT_W) ? DIST_W : CUT_W;
	localparam int SAT_W  = (DENS_W > OUT_IDX_W) ? DENS_W : OUT_IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef enum logic {
		PH_DENS,
		PH_DELTA
	} phase_t;

endpackage

// ----- rtl/density_peak_delta_search_top.sv -----
// Top level of the density peak delta search block: point memories, sequencer,
// distance pipeline and result register. Depends on dpds_pkg.
//
// Points are loaded one per cycle while busy is low; a transfer takes place when start is
// high and busy is low. The point marked last, or the one that fills the store, starts the
// evaluation and raises busy. Evaluation makes two passes over the n loaded points, a density
// pass and a delta pass. For each point the sequencer fetches it once and then streams all n
// points out of the coordinate memory, one read a cycle, through a four-stage distance unit.
// The coordinate memory has a single read port. Results come out in index order during the
// second pass, each on the result ports for one cycle with result_valid high; the receiver
// cannot hold them off. A new data set can load as soon as busy falls.
module density_peak_delta_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] x_coord,
	input  logic [15:0] y_coord,
	input  logic        last_point,
	input  logic        cutoff_sq_we,
	input  logic [32:0] cutoff_sq,
	output logic        result_valid,
	output logic [5:0]  point_index,
	output logic [5:0]  density,
	output logic [32:0] delta_sq,
	output logic [5:0]  neighbor_index,
	output logic        last_result
);

	dpds_pkg::state_t state_q, state_d;
	dpds_pkg::phase_t phase_q, phase_d;

	logic [dpds_pkg::CNT_W-1:0]  count_q;
	logic [dpds_pkg::CNT_W-1:0]  count_inc;
	logic [dpds_pkg::CNT_W-1:0]  n_q;
	logic [dpds_pkg::IDX_W-1:0]  i_q;
	logic [dpds_pkg::IDX_W-1:0]  j_q;
	logic [dpds_pkg::CUT_W-1:0]  cutoff_q;

	logic accept, eval_start, last_i, last_j, pipe_empty;
	logic rd_en, issue, capture, finish;
	logic [dpds_pkg::IDX_W-1:0] rd_addr;

	logic [dpds_pkg::COORD_BITS-1:0] x_mem [dpds_pkg::MAX_POINTS];
	logic [dpds_pkg::COORD_BITS-1:0] y_mem [dpds_pkg::MAX_POINTS];
	logic [dpds_pkg::DENS_W-1:0]     dens_mem [dpds_pkg::MAX_POINTS];

	logic [dpds_pkg::COORD_BITS-1:0] x_s1, y_s1, xi_q, yi_q;
	logic [dpds_pkg::DENS_W-1:0]     dens_s1, dens_s2, dens_s3, dens_s4, di_q;
	logic [dpds_pkg::IDX_W-1:0]      j_s1, j_s2, j_s3, j_s4;
	logic                            v_s1, v_s2, v_s3, v_s4;
	logic [dpds_pkg::COORD_BITS-1:0] dx_s2, dy_s2;
	logic [dpds_pkg::SQ_W-1:0]       sx_s3, sy_s3;
	logic [dpds_pkg::DIST_W-1:0]     d_s4;

	logic [dpds_pkg::DENS_W-1:0] cnt_q;
	logic                        found_q;
	logic [dpds_pkg::DIST_W-1:0] best_q, maxd_q;
	logic [dpds_pkg::IDX_W-1:0]  nb_q;

	logic                        result_valid_q;
	logic [dpds_pkg::OUT_IDX_W-1:0] point_index_q, density_q, neighbor_index_q;
	logic [dpds_pkg::CUT_W-1:0]  delta_sq_q;
	logic                        last_result_q;

	assign busy       = (state_q != dpds_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign count_inc  = count_q + dpds_pkg::CNT_W'(1);
	assign eval_start = accept &&
		(last_point || (count_inc == dpds_pkg::CNT_W'(dpds_pkg::MAX_POINTS)));
	assign last_i     = ((dpds_pkg::CNT_W'(i_q) + dpds_pkg::CNT_W'(1)) == n_q);
	assign last_j     = ((dpds_pkg::CNT_W'(j_q) + dpds_pkg::CNT_W'(1)) == n_q);
	assign pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpds_pkg::ST_IDLE;
			phase_q <= dpds_pkg::PH_DENS;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		rd_en   = 1'b0;
		rd_addr = i_q;
		issue   = 1'b0;
		capture = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			dpds_pkg::ST_IDLE: begin
				if (eval_start) begin
					state_d = dpds_pkg::ST_FETCH;
					phase_d = dpds_pkg::PH_DENS;
				end
			end
			dpds_pkg::ST_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = i_q;
				state_d = dpds_pkg::ST_WAIT;
			end
			dpds_pkg::ST_WAIT: begin
				capture = 1'b1;
				state_d = dpds_pkg::ST_SCAN;
			end
			dpds_pkg::ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = j_q;
				issue   = 1'b1;
				if (last_j) begin
					state_d = dpds_pkg::ST_DRAIN;
				end
			end
			dpds_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					finish = 1'b1;
					if (!last_i) begin
						state_d = dpds_pkg::ST_FETCH;
					end else if (phase_q == dpds_pkg::PH_DENS) begin
						phase_d = dpds_pkg::PH_DELTA;
						state_d = dpds_pkg::ST_FETCH;
					end else begin
						state_d = dpds_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dpds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			n_q            <= '0;
			i_q            <= '0;
			j_q            <= '0;
			cutoff_q       <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cutoff_sq_we) begin
				cutoff_q <= cutoff_sq;
			end
			if (accept) begin
				count_q <= eval_start ? '0 : count_inc;
			end
			if (eval_start) begin
				n_q <= count_inc;
				i_q <= '0;
			end
			if (capture) begin
				j_q <= '0;
			end else if (issue) begin
				j_q <= j_q + dpds_pkg::IDX_W'(1);
			end
			if (finish) begin
				i_q <= last_i ? '0 : i_q + dpds_pkg::IDX_W'(1);
			end
			v_s1           <= issue;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			result_valid_q <= finish && (phase_q == dpds_pkg::PH_DELTA);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_mem[count_q[dpds_pkg::IDX_W-1:0]] <= dpds_pkg::COORD_BITS'(x_coord);
			y_mem[count_q[dpds_pkg::IDX_W-1:0]] <= dpds_pkg::COORD_BITS'(y_coord);
		end
		if (rd_en) begin
			x_s1 <= x_mem[rd_addr];
			y_s1 <= y_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (finish && (phase_q == dpds_pkg::PH_DENS)) begin
			dens_mem[i_q] <= cnt_q;
		end
		if (rd_en) begin
			dens_s1 <= dens_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (capture) begin
			xi_q <= x_s1;
			yi_q <= y_s1;
			di_q <= dens_s1;
		end
		dx_s2   <= (x_s1 > xi_q) ? (x_s1 - xi_q) : (xi_q - x_s1);
		dy_s2   <= (y_s1 > yi_q) ? (y_s1 - yi_q) : (yi_q - y_s1);
		j_s2    <= j_s1;
		dens_s2 <= dens_s1;
		sx_s3   <= dpds_pkg::SQ_W'(dx_s2) * dpds_pkg::SQ_W'(dx_s2);
		sy_s3   <= dpds_pkg::SQ_W'(dy_s2) * dpds_pkg::SQ_W'(dy_s2);
		j_s3    <= j_s2;
		dens_s3 <= dens_s2;
		d_s4    <= dpds_pkg::DIST_W'(sx_s3) + dpds_pkg::DIST_W'(sy_s3);
		j_s4    <= j_s3;
		dens_s4 <= dens_s3;
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			nb_q    <= '0;
			maxd_q  <= '0;
		end else if (v_s4 && (j_s4 != i_q)) begin
			if (phase_q == dpds_pkg::PH_DENS) begin
				if (dpds_pkg::CMP_W'(d_s4) < dpds_pkg::CMP_W'(cutoff_q)) begin
					cnt_q <= cnt_q + dpds_pkg::DENS_W'(1);
				end
			end else begin
				if (d_s4 > maxd_q) begin
					maxd_q <= d_s4;
				end
				if ((dens_s4 > di_q) && (!found_q || (d_s4 < best_q))) begin
					found_q <= 1'b1;
					best_q  <= d_s4;
					nb_q    <= j_s4;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish && (phase_q == dpds_pkg::PH_DELTA)) begin
			point_index_q <= dpds_pkg::OUT_IDX_W'(i_q);
			density_q <= (dpds_pkg::SAT_W'(di_q) > dpds_pkg::SAT_W'(dpds_pkg::OUT_DENS_MAX)) ?
				dpds_pkg::OUT_IDX_W'(dpds_pkg::OUT_DENS_MAX) : dpds_pkg::OUT_IDX_W'(di_q);
			delta_sq_q <= found_q ? dpds_pkg::CUT_W'(best_q) : dpds_pkg::CUT_W'(maxd_q);
			neighbor_index_q <= found_q ? dpds_pkg::OUT_IDX_W'(nb_q) : '0;
			last_result_q <= last_i;
		end
	end

	assign result_valid   = result_valid_q;
	assign point_index    = point_index_q;
	assign density        = density_q;
	assign delta_sq       = delta_sq_q;
	assign neighbor_index = neighbor_index_q;
	assign last_result    = last_result_q;

	// A result only follows the completion of a point in the delta pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past((state_q == dpds_pkg::ST_DRAIN) && (phase_q == dpds_pkg::PH_DELTA)))
		else $error("result without a finished delta pass point");

	// The scan never reads past the loaded points.
	assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (dpds_pkg::CNT_W'(j_q) < n_q))
		else $error("scan read beyond the loaded points");

	// The final result coincides with the return to loading.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |-> (state_q == dpds_pkg::ST_IDLE))
		else $error("final result while still evaluating");

endmodule
